// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a second condition in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Checks that a condition implies a second condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== hw/rtl/gcma_pkg.sv =====
`default_nettype none
package gcma_pkg;
    localparam int AccelFracBitsDefault = 12;
    localparam int RegW = 20;
    localparam int AccW = 21;
    localparam int QW = 16;
    localparam int DtW = 16;
    localparam int IdxW = 2;
    localparam int ProdW = 96;

    localparam logic [IdxW-1:0] REG_TAU = 2'd0;
    localparam logic [IdxW-1:0] REG_GRAV = 2'd1;
    localparam logic [IdxW-1:0] REG_DBXY = 2'd2;
    localparam logic [IdxW-1:0] REG_DBZ = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QPROD,
        ST_GRAV,
        ST_NUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_NAV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctrl_t;

    function automatic logic [RegW-1:0] round_reg(input int unsigned hundredths, input int f);
        longint unsigned v;
        v = ((longint'(hundredths) << f) + 64'd50) / 64'd100;
        return v[RegW-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/gcma_stream_if.sv =====
`default_nettype none
interface gcma_stream_if #(
    parameter int W = 8
);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gravity_compensated_motion_accel.sv =====
// Gravity-compensated motion acceleration. One transaction in carries an attitude quaternion,
// a body accelerometer sample and dt; one transaction out carries the deadbanded, saturated
// navigation-frame motion acceleration. A single 34x33 signed multiplier and a radix-2 divider
// are reused under a sequencer; when tau plus dt is zero the three divisions are skipped. The
// block is not ready while it works. A finished result sits in its own output register, so the
// next input can be accepted in the same cycle that the result appears, and only a result that
// is still waiting when the next one is finished stalls the block. The user must write registers
// through the configuration port only while the block is idle; the block itself does not enforce it.
`default_nettype none
module gravity_compensated_motion_accel #(
    parameter int ACCEL_FRAC_BITS = gcma_pkg::AccelFracBitsDefault
) (
    input  wire logic clk,
    input  wire logic rst_n,
    gcma_stream_if.sink in_ch,
    gcma_stream_if.source out_ch,
    input  wire logic cfg_we,
    input  wire logic [gcma_pkg::IdxW-1:0] cfg_index,
    input  wire logic [gcma_pkg::RegW-1:0] cfg_data
);
    import gcma_pkg::*;

    localparam logic signed [AccW-1:0] VMax = {1'b0, {(AccW-1){1'b1}}};
    localparam logic signed [AccW-1:0] VMin = {1'b1, {(AccW-1){1'b0}}};

    state_t state_reg, state_next;
    logic [RegW-1:0] tau_reg, grav_reg, dbxy_reg, dbz_reg;
    logic signed [AccW-1:0] filt_reg [3];
    logic signed [QW-1:0] q_reg [4];
    logic signed [AccW-1:0] acc_reg [3];
    logic [DtW-1:0] dt_reg;
    logic signed [33:0] pp_reg [9];
    logic signed [AccW-1:0] nav_reg [3];
    logic [3*AccW-1:0] out_data_reg;
    logic [3:0] step_reg, step_next;
    logic [1:0] ax_reg;
    logic signed [71:0] accum_reg;
    logic signed [AccW+2:0] diff_reg;
    logic out_valid_reg;

    logic signed [33:0] ma;
    logic signed [32:0] mb;
    logic signed [66:0] mp;
    logic signed [66:0] mp_reg;
    logic signed [33:0] mrow [3][3];
    logic signed [33:0] one_q30;
    logic [20:0] den;
    logic den_zero;
    logic signed [71:0] num_s;
    logic num_neg;
    logic [63:0] num_mag;
    logic div_busy;
    logic [63:0] div_q;
    div_ctrl_t dctl;
    logic signed [65:0] qsgn;
    logic signed [71:0] rnd;
    logic signed [71:0] nav_r;
    logic [72:0] nav_abs;
    logic [RegW-1:0] th;
    logic out_load;

    assign one_q30 = 34'sd1 <<< 30;
    // pp: 0 q1q1, 1 q2q2, 2 q3q3, 3 q1q2, 4 q0q3, 5 q1q3, 6 q0q2, 7 q2q3, 8 q0q1
    always_comb
    begin
        mrow[0][0] = one_q30 - 34'(2 * (pp_reg[1] + pp_reg[2]));
        mrow[0][1] = 34'(2 * (pp_reg[3] - pp_reg[4]));
        mrow[0][2] = 34'(2 * (pp_reg[5] + pp_reg[6]));
        mrow[1][0] = 34'(2 * (pp_reg[3] + pp_reg[4]));
        mrow[1][1] = one_q30 - 34'(2 * (pp_reg[0] + pp_reg[2]));
        mrow[1][2] = 34'(2 * (pp_reg[7] - pp_reg[8]));
        mrow[2][0] = 34'(2 * (pp_reg[5] - pp_reg[6]));
        mrow[2][1] = 34'(2 * (pp_reg[7] + pp_reg[8]));
        mrow[2][2] = one_q30 - 34'(2 * (pp_reg[0] + pp_reg[1]));
    end

    assign den = 21'(tau_reg) + 21'(dt_reg);
    assign den_zero = (den == '0);

    // Shared multiplier operand selection.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            ST_QPROD:
            begin
                unique case (step_reg)
                    4'd0: begin ma = 34'(q_reg[1]); mb = 33'(q_reg[1]); end
                    4'd1: begin ma = 34'(q_reg[2]); mb = 33'(q_reg[2]); end
                    4'd2: begin ma = 34'(q_reg[3]); mb = 33'(q_reg[3]); end
                    4'd3: begin ma = 34'(q_reg[1]); mb = 33'(q_reg[2]); end
                    4'd4: begin ma = 34'(q_reg[0]); mb = 33'(q_reg[3]); end
                    4'd5: begin ma = 34'(q_reg[1]); mb = 33'(q_reg[3]); end
                    4'd6: begin ma = 34'(q_reg[0]); mb = 33'(q_reg[2]); end
                    4'd7: begin ma = 34'(q_reg[2]); mb = 33'(q_reg[3]); end
                    4'd8: begin ma = 34'(q_reg[0]); mb = 33'(q_reg[1]); end
                    default: begin ma = '0; mb = '0; end
                endcase
            end
            ST_GRAV:
            begin
                ma = mrow[2][ax_reg];
                mb = 33'({1'b0, grav_reg});
            end
            ST_NUM:
            begin
                if (step_reg == 4'd0)
                begin
                    ma = 34'(diff_reg);
                    mb = 33'({1'b0, dt_reg});
                end
                else
                begin
                    ma = 34'(filt_reg[ax_reg]);
                    mb = 33'({1'b0, tau_reg});
                end
            end
            ST_NAV:
            begin
                if (step_reg < 4'd3)
                begin
                    ma = mrow[ax_reg][step_reg[1:0]];
                    mb = 33'(filt_reg[step_reg[1:0]]);
                end
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end
    assign mp = ma * mb;

    assign num_s = accum_reg;
    assign num_neg = num_s[71];
    assign num_mag = num_neg ? 64'(-num_s) + 64'(den >> 1) : 64'(num_s) + 64'(den >> 1);
    assign dctl.start = (state_reg == ST_DIV_START);
    assign dctl.busy = div_busy;
    assign dctl.done = (state_reg == ST_DIV_WAIT) && !div_busy;

    gcma_divider u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(dctl.start),
        .num_mag(num_mag),
        .den(den),
        .busy(div_busy),
        .quot(div_q)
    );

    assign qsgn = num_neg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    assign rnd = (accum_reg + (72'sd1 <<< 29)) >>> 30;
    assign nav_r = rnd;
    assign nav_abs = nav_r[71] ? 73'(-nav_r) : 73'(nav_r);
    assign th = (ax_reg == 2'd2) ? dbz_reg : dbxy_reg;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = ST_QPROD;
                    step_next = '0;
                end
            ST_QPROD:
                if (step_reg == 4'd9)
                begin
                    state_next = ST_GRAV;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            ST_GRAV:
                if (step_reg == 4'd1)
                begin
                    state_next = ST_NUM;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            ST_NUM:
                if (step_reg == 4'd2)
                begin
                    state_next = den_zero ? ((ax_reg == 2'd2) ? ST_NAV : ST_GRAV) : ST_DIV_START;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            ST_DIV_START:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (dctl.done)
                begin
                    state_next = (ax_reg == 2'd2) ? ST_NAV : ST_GRAV;
                end
            ST_NAV:
                if (step_reg == 4'd4)
                begin
                    step_next = '0;
                    state_next = (ax_reg == 2'd2) ? ST_OUT : ST_NAV;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            ST_OUT:
                if (!out_ch.valid || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            ax_reg <= '0;
            out_valid_reg <= 1'b0;
            tau_reg <= 20'd8900;
            grav_reg <= round_reg(981, ACCEL_FRAC_BITS);
            dbxy_reg <= round_reg(2, ACCEL_FRAC_BITS);
            dbz_reg <= round_reg(4, ACCEL_FRAC_BITS);
            for (int i = 0; i < 3; i++)
            begin
                filt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TAU: tau_reg <= cfg_data;
                    REG_GRAV: grav_reg <= cfg_data;
                    REG_DBXY: dbxy_reg <= cfg_data;
                    REG_DBZ: dbz_reg <= cfg_data;
                    default: tau_reg <= tau_reg;
                endcase
            end
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            if (state_reg == ST_IDLE)
            begin
                ax_reg <= '0;
            end
            if ((state_reg == ST_NUM && step_reg == 4'd2 && den_zero)
                || (state_reg == ST_DIV_WAIT && dctl.done))
            begin
                ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
            end
            if (state_reg == ST_NAV && step_reg == 4'd4)
            begin
                ax_reg <= ax_reg + 2'd1;
            end
            if (state_reg == ST_DIV_WAIT && dctl.done)
            begin
                if (qsgn > 66'(VMax))
                    filt_reg[ax_reg] <= VMax;
                else if (qsgn < 66'(VMin))
                    filt_reg[ax_reg] <= VMin;
                else
                    filt_reg[ax_reg] <= qsgn[AccW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mp_reg <= mp;
        if (in_ch.valid && in_ch.ready)
        begin
            q_reg[0] <= in_ch.data[15:0];
            q_reg[1] <= in_ch.data[31:16];
            q_reg[2] <= in_ch.data[47:32];
            q_reg[3] <= in_ch.data[63:48];
            acc_reg[0] <= in_ch.data[84:64];
            acc_reg[1] <= in_ch.data[105:85];
            acc_reg[2] <= in_ch.data[126:106];
            dt_reg <= in_ch.data[142:127];
        end
        if (out_load)
        begin
            out_data_reg <= {nav_reg[2], nav_reg[1], nav_reg[0]};
        end
        if (state_reg == ST_QPROD && step_reg != 4'd0)
        begin
            pp_reg[step_reg - 4'd1] <= 34'(mp_reg);
        end
        if (state_reg == ST_GRAV && step_reg == 4'd1)
        begin
            diff_reg <= 24'(acc_reg[ax_reg]) - 24'((72'(mp_reg) + (72'sd1 <<< 29)) >>> 30);
        end
        if (state_reg == ST_NUM)
        begin
            if (step_reg == 4'd1)
                accum_reg <= 72'(mp_reg);
            else if (step_reg == 4'd2)
                accum_reg <= accum_reg + 72'(mp_reg);
        end
        if (state_reg == ST_NAV)
        begin
            if (step_reg == 4'd0)
                accum_reg <= '0;
            else if (step_reg != 4'd4)
                accum_reg <= accum_reg + 72'(mp_reg);
            else
            begin
                if (nav_abs < 73'(th))
                    nav_reg[ax_reg] <= '0;
                else if (nav_r > 72'(VMax))
                    nav_reg[ax_reg] <= VMax;
                else if (nav_r < 72'(VMin))
                    nav_reg[ax_reg] <= VMin;
                else
                    nav_reg[ax_reg] <= nav_r[AccW-1:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/gcma_divider.sv =====
`default_nettype none
module gcma_divider (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [63:0] num_mag,
    input  wire logic [20:0] den,
    output logic busy,
    output logic [63:0] quot
);
    import gcma_pkg::*;

    logic [63:0] q_reg, q_next;
    logic [21:0] r_reg, r_next;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic [21:0] trial;

    assign busy = busy_reg;
    assign quot = q_reg;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg[20:0], q_reg[63]};
        if (start)
        begin
            q_next = num_mag;
            r_next = '0;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule
`default_nettype wire

// ===== hw/rtl/gcma_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module gcma_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [3*gcma_pkg::AccW-1:0] out_data
);
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")
    `ASSERT_NEXT(a_data_holds, clk, rst_n, out_valid && !out_ready, $stable(out_data), "result changed")
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
endmodule

bind gravity_compensated_motion_accel gcma_checker u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
    import gcma_pkg::*;

    typedef struct packed {
        logic [DtW-1:0] dt;
        logic signed [AccW-1:0] az;
        logic signed [AccW-1:0] ay;
        logic signed [AccW-1:0] ax;
        logic signed [QW-1:0] qz;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qw;
    } sample_t;

    typedef struct packed {
        logic signed [AccW-1:0] z;
        logic signed [AccW-1:0] y;
        logic signed [AccW-1:0] x;
    } motion_t;

    typedef struct {
        sample_t s;
        bit has_exp;
        motion_t exp_out;
    } stim_row_t;

    localparam longint VMax = 1048575;
    localparam longint VMin = -1048576;
    localparam int CycleLimit = 3000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IdxW-1:0] cfg_index;
    logic [RegW-1:0] cfg_data;

    gcma_stream_if #(.W($bits(sample_t))) in_ch ();
    gcma_stream_if #(.W($bits(motion_t))) out_ch ();

    gravity_compensated_motion_accel dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    logic [RegW-1:0] tau_reg;
    logic [RegW-1:0] grav_reg;
    logic [RegW-1:0] dbxy_reg;
    logic [RegW-1:0] dbz_reg;
    longint filt [3];
    motion_t motion_q [$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    function automatic longint sat21(longint v);
        if (v > VMax)
        begin
            return VMax;
        end
        if (v < VMin)
        begin
            return VMin;
        end
        return v;
    endfunction

    function automatic longint round_q30(longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint deadband(longint v, logic [RegW-1:0] th);
        longint a;
        a = (v < 0) ? -v : v;
        return (a < longint'(th)) ? 0 : v;
    endfunction

    function automatic motion_t compensate(sample_t s);
        longint q0, q1, q2, q3, m [3][3], acc [3], nav [3];
        longint dt, tau, den, num, gb, diff, sum;
        motion_t r;
        q0 = s.qw;
        q1 = s.qx;
        q2 = s.qy;
        q3 = s.qz;
        acc[0] = s.ax;
        acc[1] = s.ay;
        acc[2] = s.az;
        dt = s.dt;
        tau = tau_reg;
        den = tau + dt;
        m[0][0] = (64'sd1 <<< 30) - 2 * (q2 * q2 + q3 * q3);
        m[0][1] = 2 * (q1 * q2 - q0 * q3);
        m[0][2] = 2 * (q1 * q3 + q0 * q2);
        m[1][0] = 2 * (q1 * q2 + q0 * q3);
        m[1][1] = (64'sd1 <<< 30) - 2 * (q1 * q1 + q3 * q3);
        m[1][2] = 2 * (q2 * q3 - q0 * q1);
        m[2][0] = 2 * (q1 * q3 - q0 * q2);
        m[2][1] = 2 * (q2 * q3 + q0 * q1);
        m[2][2] = (64'sd1 <<< 30) - 2 * (q1 * q1 + q2 * q2);
        for (int i = 0; i < 3; i++)
        begin
            gb = round_q30(m[2][i] * longint'(grav_reg));
            diff = acc[i] - gb;
            if (den != 0)
            begin
                num = diff * dt + filt[i] * tau;
                if (num >= 0)
                begin
                    filt[i] = sat21((num + den / 2) / den);
                end
                else
                begin
                    filt[i] = sat21(-((-num + den / 2) / den));
                end
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            sum = m[i][0] * filt[0] + m[i][1] * filt[1] + m[i][2] * filt[2];
            nav[i] = round_q30(sum);
        end
        r.x = sat21(deadband(nav[0], dbxy_reg));
        r.y = sat21(deadband(nav[1], dbxy_reg));
        r.z = sat21(deadband(nav[2], dbz_reg));
        return r;
    endfunction

    task automatic write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TAU: tau_reg = value;
            REG_GRAV: grav_reg = value;
            REG_DBXY: dbxy_reg = value;
            default: dbz_reg = value;
        endcase
    endtask

    // Valid stays high between back-to-back transactions; this task drops it only for an idle gap.
    task automatic send_sample(sample_t s, bit has_exp, motion_t exp_out);
        motion_t pred;
        bit fire;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= s;
        fire = 1'b0;
        while (!fire)
        begin
            @(negedge clk);
            fire = in_ch.ready;
            @(posedge clk);
        end
        pred = compensate(s);
        motion_q.push_back(has_exp ? exp_out : pred);
    endtask

    task automatic drain();
        @(posedge clk);
        in_ch.valid <= 1'b0;
        while (motion_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        int kind;
        s = '0;
        s.qw = 16'($urandom);
        s.qx = 16'($urandom);
        s.qy = 16'($urandom);
        s.qz = 16'($urandom);
        kind = $urandom_range(3);
        if (kind == 0)
        begin
            s.qw = 16'sd23170 + $signed(16'($urandom_range(400))) - 16'sd200;
            s.qx = $signed(16'($urandom_range(16000))) - 16'sd8000;
            s.qy = $signed(16'($urandom_range(16000))) - 16'sd8000;
            s.qz = $signed(16'($urandom_range(16000))) - 16'sd8000;
        end
        if (kind <= 1)
        begin
            s.ax = $signed(21'($urandom_range(200000))) - 21'sd100000;
            s.ay = $signed(21'($urandom_range(200000))) - 21'sd100000;
            s.az = $signed(21'($urandom_range(200000))) - 21'sd60000;
        end
        else
        begin
            s.ax = 21'($urandom);
            s.ay = 21'($urandom);
            s.az = 21'($urandom);
        end
        case ($urandom_range(4))
            0: s.dt = 16'd0;
            1: s.dt = 16'($urandom_range(2000, 500));
            2: s.dt = 16'($urandom_range(16));
            default: s.dt = 16'($urandom);
        endcase
        return s;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("gravity_compensated_motion_accel verification failed");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(negedge clk)
    begin
        motion_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (motion_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = motion_q.pop_front();
                if (got.x !== want.x)
                begin
                    $display("%0t: motion_nav_x expected %0d actual %0d", $time, want.x, got.x);
                    errors++;
                end
                if (got.y !== want.y)
                begin
                    $display("%0t: motion_nav_y expected %0d actual %0d", $time, want.y, got.y);
                    errors++;
                end
                if (got.z !== want.z)
                begin
                    $display("%0t: motion_nav_z expected %0d actual %0d", $time, want.z, got.z);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        sample_t s;
        int wait_cycles;
        logic [RegW-1:0] phase_cfg [8][4];

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        errors = 0;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        tau_reg = 20'd8900;
        grav_reg = 20'd40182;
        dbxy_reg = 20'd82;
        dbz_reg = 20'd164;
        for (int i = 0; i < 3; i++)
        begin
            filt[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // After reset the filter is zero, and a zero dt keeps it there.
        row.has_exp = 1'b1;
        row.exp_out = '0;
        row.s = '0;
        rows.push_back(row);
        row.s.qw = 16'sd32767;
        rows.push_back(row);
        row.has_exp = 1'b0;
        row.s = '{16'hffff, 21'sd1048575, 21'sd1048575, 21'sd1048575,
            16'sd0, 16'sd0, 16'sd0, 16'sd32767};
        rows.push_back(row);
        row.s = '{16'hffff, -21'sd1048576, -21'sd1048576, -21'sd1048576,
            16'sd0, 16'sd0, 16'sd0, 16'sd0};
        rows.push_back(row);
        row.s = '{16'd1000, 21'sd0, 21'sd0, 21'sd0,
            -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        rows.push_back(row);
        row.s = '{16'd1000, 21'sd40182, -21'sd1048576, 21'sd1048575,
            16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        rows.push_back(row);
        row.s = '{16'd65535, 21'sd163, -21'sd81, 21'sd81,
            16'sd0, 16'sd0, 16'sd23170, 16'sd23170};
        rows.push_back(row);
        row.s = '{16'd1, 21'sd40182, 21'sd0, 21'sd5000,
            16'sd0, -16'sd23170, 16'sd0, 16'sd23170};
        rows.push_back(row);
        row.s = '{16'd8900, 21'sd164, 21'sd82, 21'sd82,
            16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
        rows.push_back(row);
        row.s = '{16'd0, -21'sd40182, 21'sd1, -21'sd1,
            16'sd1, 16'sd32767, -16'sd32768, 16'sd100};
        rows.push_back(row);
        row.s = '{16'd500, 21'sd40182, 21'sd0, 21'sd0,
            16'sd0, 16'sd0, 16'sd0, 16'sd32767};
        rows.push_back(row);
        foreach (rows[i])
        begin
            send_sample(rows[i].s, rows[i].has_exp, rows[i].exp_out);
        end
        drain();

        phase_cfg[0] = '{20'd8900, 20'd40182, 20'd82, 20'd164};
        phase_cfg[1] = '{20'd0, 20'd0, 20'd0, 20'd0};
        phase_cfg[2] = '{20'd1000000, 20'hfffff, 20'hfffff, 20'hfffff};
        phase_cfg[3] = '{20'hfffff, 20'd40182, 20'd4000, 20'd50};
        phase_cfg[4] = '{20'd1, 20'd500000, 20'd1, 20'd1};
        phase_cfg[5] = '{20'd200, 20'd40182, 20'd82, 20'd164};
        phase_cfg[6] = '{20'd0, 20'd40182, 20'd20000, 20'd300000};
        phase_cfg[7] = '{20'd50000, 20'd1000, 20'd82, 20'd0};

        for (int p = 0; p < 8; p++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                write_reg(r[IdxW-1:0], phase_cfg[p][r]);
            end
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct = 33;
                    recv_stall_pct = 33;
                end
            endcase
            if (p == 4)
            begin
                hold_off = 3000;
            end
            for (int k = 0; k < 175; k++)
            begin
                s = random_sample();
                send_sample(s, 1'b0, '0);
            end
            drain();
        end

        wait_cycles = 0;
        while (motion_q.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (errors == 0 && motion_q.size() == 0)
        begin
            $display("gravity_compensated_motion_accel verification clean");
        end
        else
        begin
            $display("gravity_compensated_motion_accel verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
